FILE: rtl/jic_pkg.sv
`timescale 1ns / 1ps

package jic_pkg;

  localparam int MAX_DEVICES = 8;
  localparam int MAX_BUTTONS = 32;
  localparam int MAX_HATS    = 4;

  localparam int AXIS_COUNT   = 6;
  localparam int SLIDER_COUNT = 2;

  localparam int DEV_IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int BTN_IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
  localparam int HAT_IDX_W = (MAX_HATS > 1) ? $clog2(MAX_HATS) : 1;

  localparam logic [14:0] FULL_SCALE = 15'h7FFF;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [14:0] DEAD_ZONE_RST  = 15'd3277;
  localparam logic [14:0] SATURATION_RST = 15'd29491;
  localparam logic [15:0] GAIN_RST       = 16'd5120;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEAD_ZONE  = 2'd0,
    REG_SATURATION = 2'd1,
    REG_GAIN       = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_AXIS    = 3'd0,
    CMD_SLIDER  = 3'd1,
    CMD_TRIGGER = 3'd2,
    CMD_BUTTON  = 3'd3,
    CMD_HAT     = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    EV_AXIS       = 3'd0,
    EV_SLIDER     = 3'd1,
    EV_BTN_DOWN   = 3'd2,
    EV_BTN_UP     = 3'd3,
    EV_HAT_OFFSET = 3'd4,
    EV_HAT_CENTER = 3'd5
  } event_kind_t;

  typedef enum logic [3:0] {
    HAT_UP         = 4'd1,
    HAT_RIGHT      = 4'd2,
    HAT_RIGHT_UP   = 4'd3,
    HAT_DOWN       = 4'd4,
    HAT_RIGHT_DOWN = 4'd6,
    HAT_LEFT       = 4'd8,
    HAT_LEFT_UP    = 4'd9,
    HAT_LEFT_DOWN  = 4'd12
  } hat_mask_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [2:0]         device;
    logic [4:0]         channel;
    logic signed [15:0] raw_value;
  } item_t;

  // level store write strobes, all qualified by the item leaving the input stage
  typedef struct packed {
    logic button;
    logic hat;
    logic clear;
  } lvl_ctrl_t;

  typedef struct packed {
    logic btn_change;
    logic hat_change;
  } lvl_stat_t;

  // {offset, eighth-turn code clockwise from up}
  function automatic logic [3:0] hat_code(input logic [3:0] mask);
    logic [3:0] r;
    r = 4'b0000;
    unique case (mask)
      HAT_UP:         r = 4'b1000;
      HAT_RIGHT_UP:   r = 4'b1001;
      HAT_RIGHT:      r = 4'b1010;
      HAT_RIGHT_DOWN: r = 4'b1011;
      HAT_DOWN:       r = 4'b1100;
      HAT_LEFT_DOWN:  r = 4'b1101;
      HAT_LEFT:       r = 4'b1110;
      HAT_LEFT_UP:    r = 4'b1111;
      default:        r = 4'b0000;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/jic_item_if.sv
`timescale 1ns / 1ps

interface jic_item_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [2:0]         device;
  logic [4:0]         channel;
  logic signed [15:0] raw_value;

  modport source (output valid, command, device, channel, raw_value, input ready);
  modport sink (input valid, command, device, channel, raw_value, output ready);
endinterface

FILE: rtl/jic_event_if.sv
`timescale 1ns / 1ps

interface jic_event_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_device;
  logic [2:0]         event_kind;
  logic [4:0]         out_channel;
  logic signed [15:0] value;

  modport source (output valid, out_device, event_kind, out_channel, value, input ready);
  modport sink (input valid, out_device, event_kind, out_channel, value, output ready);
endinterface

FILE: rtl/jic_cfg_if.sv
`timescale 1ns / 1ps

interface jic_cfg_if;
  import jic_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

FILE: rtl/joystick_input_conditioner.sv
`timescale 1ns / 1ps

// Conditions controller samples: axis dead zone and gain scaling, slider and
// trigger mapping, and change detection on button and hat levels per device.
// One sample is accepted every clock unless an event is stalled on the event
// channel. A sample is held in an input register, evaluated in one pass (one
// 15x16 multiply for axis gain, a compare and a state lookup for buttons and
// hats) and its event, if any, lands in the result register. Button and hat
// levels update as the sample leaves the input register, so the next sample
// sees them at once. Samples that produce no event never wait on the event
// channel. Configuration registers are written through the cfg channel, which
// is always ready, and must be written only while the block is idle.
module joystick_input_conditioner import jic_pkg::*; (
  input logic clk,
  input logic rst,
  jic_item_if.sink    samples,
  jic_event_if.source events,
  jic_cfg_if.sink     cfg
);

  logic [14:0] dead_zone;
  logic [14:0] saturation;
  logic [15:0] gain;

  item_t s1_item;
  logic  s1_valid;
  logic  s1_go;
  logic  s2_free;

  logic signed [15:0] axis_value;
  logic signed [15:0] slider_value;
  logic signed [15:0] trigger_value;

  lvl_ctrl_t lvl_ctrl;
  lvl_stat_t lvl_stat;

  logic               ev_has;
  logic [2:0]         ev_kind;
  logic signed [15:0] ev_value;
  logic               dev_ok;
  logic [3:0]         hat_info;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone  <= DEAD_ZONE_RST;
      saturation <= SATURATION_RST;
      gain       <= GAIN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_DEAD_ZONE:  dead_zone  <= cfg.data[14:0];
        REG_SATURATION: saturation <= cfg.data[14:0];
        REG_GAIN:       gain       <= cfg.data;
        default: ;
      endcase
    end
  end

  // input stage
  assign s2_free       = !events.valid || events.ready;
  assign s1_go         = s1_valid && (!ev_has || s2_free);
  assign samples.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_item.command   <= samples.command;
      s1_item.device    <= samples.device;
      s1_item.channel   <= samples.channel;
      s1_item.raw_value <= samples.raw_value;
    end
  end

  jic_axis_scale u_axis (
    .raw_value     (s1_item.raw_value),
    .dead_zone     (dead_zone),
    .saturation    (saturation),
    .gain          (gain),
    .axis_value    (axis_value),
    .slider_value  (slider_value),
    .trigger_value (trigger_value)
  );

  jic_levels u_levels (
    .clk  (clk),
    .rst  (rst),
    .item (s1_item),
    .ctrl (lvl_ctrl),
    .stat (lvl_stat)
  );

  // event decode
  always_comb begin
    dev_ok   = int'(s1_item.device) < MAX_DEVICES;
    hat_info = hat_code(s1_item.raw_value[3:0]);
    ev_has   = 1'b0;
    ev_kind  = EV_AXIS;
    ev_value = 16'sd0;
    lvl_ctrl = '0;
    unique case (cmd_t'(s1_item.command))
      CMD_AXIS: begin
        ev_has   = dev_ok && (int'(s1_item.channel) < AXIS_COUNT);
        ev_kind  = EV_AXIS;
        ev_value = axis_value;
      end
      CMD_SLIDER: begin
        ev_has   = dev_ok && (int'(s1_item.channel) < SLIDER_COUNT);
        ev_kind  = EV_SLIDER;
        ev_value = slider_value;
      end
      CMD_TRIGGER: begin
        ev_has   = dev_ok && (int'(s1_item.channel) < SLIDER_COUNT);
        ev_kind  = EV_SLIDER;
        ev_value = trigger_value;
      end
      CMD_BUTTON: begin
        ev_has          = dev_ok && (int'(s1_item.channel) < MAX_BUTTONS)
                          && lvl_stat.btn_change;
        ev_kind         = s1_item.raw_value[0] ? EV_BTN_DOWN : EV_BTN_UP;
        lvl_ctrl.button = s1_go && ev_has;
      end
      CMD_HAT: begin
        ev_has       = dev_ok && (int'(s1_item.channel) < MAX_HATS)
                       && lvl_stat.hat_change;
        ev_kind      = hat_info[3] ? EV_HAT_OFFSET : EV_HAT_CENTER;
        ev_value     = hat_info[3] ? $signed({13'd0, hat_info[2:0]}) : 16'sd0;
        lvl_ctrl.hat = s1_go && ev_has;
      end
      CMD_CLEAR: begin
        lvl_ctrl.clear = s1_go && dev_ok;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      events.valid <= 1'b0;
    end else if (s1_go && ev_has) begin
      events.valid <= 1'b1;
    end else if (events.ready) begin
      events.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && ev_has) begin
      events.out_device  <= s1_item.device;
      events.event_kind  <= ev_kind;
      events.out_channel <= s1_item.channel;
      events.value       <= ev_value;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |-> !samples.ready)
    else $error("input accepted while input stage is stalled");

  a_event_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(events.valid) |-> $past(s1_valid))
    else $error("event raised without an item in the input stage");

  a_axis_in_range: assert property (@(posedge clk) disable iff (rst)
    events.valid && (events.event_kind == EV_AXIS) |-> events.value != 16'sh8000)
    else $error("axis value outside full scale");

  a_hat_code_range: assert property (@(posedge clk) disable iff (rst)
    events.valid && (events.event_kind == EV_HAT_OFFSET) |-> events.value[15:3] == 13'd0)
    else $error("hat code out of range");

  a_zero_value_events: assert property (@(posedge clk) disable iff (rst)
    events.valid && (events.event_kind == EV_BTN_DOWN || events.event_kind == EV_BTN_UP
      || events.event_kind == EV_HAT_CENTER) |-> events.value == 16'sd0)
    else $error("button or centered hat event carries a value");

endmodule

FILE: rtl/jic_axis_scale.sv
`timescale 1ns / 1ps

module jic_axis_scale import jic_pkg::*; (
  input  logic signed [15:0] raw_value,
  input  logic [14:0]        dead_zone,
  input  logic [14:0]        saturation,
  input  logic [15:0]        gain,
  output logic signed [15:0] axis_value,
  output logic signed [15:0] slider_value,
  output logic signed [15:0] trigger_value
);

  logic        neg;
  logic [15:0] abs_raw;
  logic [14:0] mag;
  logic [14:0] diff;
  logic [30:0] prod;
  logic [31:0] rounded;
  logic [19:0] scaled;
  logic [14:0] capped;
  logic [14:0] mag_out;

  logic [15:0] u;
  logic [16:0] w;
  logic [31:0] x;
  logic [16:0] t;
  logic [15:0] q;

  always_comb begin
    neg     = raw_value[15];
    abs_raw = neg ? (16'd0 - raw_value) : raw_value;
    // most negative sample clamps to -full scale
    mag     = abs_raw[15] ? FULL_SCALE : abs_raw[14:0];
    diff    = mag - dead_zone;
    prod    = 31'(diff) * 31'(gain);
    rounded = {1'b0, prod} + 32'd2048;
    scaled  = rounded[31:12];
    capped  = (scaled > 20'(FULL_SCALE)) ? FULL_SCALE : scaled[14:0];
    if (mag <= dead_zone) begin
      mag_out = 15'd0;
    end else if (mag >= saturation) begin
      mag_out = FULL_SCALE;
    end else begin
      mag_out = capped;
    end
    axis_value = neg ? (16'sd0 - $signed({1'b0, mag_out})) : $signed({1'b0, mag_out});
  end

  // round-half-up of u*32767/65535 reduces to floor(32767*(u+1)/65535);
  // 65536 = 65535 + 1, so high half plus low half needs one correction step
  always_comb begin
    u = {~raw_value[15], raw_value[14:0]};
    w = {1'b0, u} + 17'd1;
    x = {w, 15'd0} - {15'd0, w};
    t = {1'b0, x[31:16]} + {1'b0, x[15:0]};
    q = x[31:16] + ((t >= 17'd65535) ? 16'd1 : 16'd0);
    slider_value = $signed(q);
  end

  assign trigger_value = raw_value[15] ? 16'sd0 : raw_value;

endmodule

FILE: rtl/jic_levels.sv
`timescale 1ns / 1ps

module jic_levels import jic_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  item_t     item,
  input  lvl_ctrl_t ctrl,
  output lvl_stat_t stat
);

  logic [MAX_BUTTONS-1:0] btn_levels [MAX_DEVICES];
  logic [3:0]             hat_levels [MAX_DEVICES][MAX_HATS];

  logic [DEV_IDX_W-1:0] dev_idx;
  logic [BTN_IDX_W-1:0] btn_idx;
  logic [HAT_IDX_W-1:0] hat_idx;

  assign dev_idx = item.device[DEV_IDX_W-1:0];
  assign btn_idx = item.channel[BTN_IDX_W-1:0];
  assign hat_idx = item.channel[HAT_IDX_W-1:0];

  assign stat.btn_change = btn_levels[dev_idx][btn_idx] != item.raw_value[0];
  assign stat.hat_change = hat_levels[dev_idx][hat_idx] != item.raw_value[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < MAX_DEVICES; d++) begin
        btn_levels[d] <= '0;
        for (int h = 0; h < MAX_HATS; h++) begin
          hat_levels[d][h] <= 4'd0;
        end
      end
    end else begin
      priority if (ctrl.clear) begin
        btn_levels[dev_idx] <= '0;
        for (int h = 0; h < MAX_HATS; h++) begin
          hat_levels[dev_idx][h] <= 4'd0;
        end
      end else if (ctrl.button) begin
        btn_levels[dev_idx][btn_idx] <= item.raw_value[0];
      end else if (ctrl.hat) begin
        hat_levels[dev_idx][hat_idx] <= item.raw_value[3:0];
      end
    end
  end

endmodule

FILE: dv/tb_joystick_input_conditioner.sv
`timescale 1ns / 1ps

module tb_joystick_input_conditioner;
  import jic_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_STALL   = 300;
  localparam int RANDOM_CHUNK = 305;

  typedef struct {
    logic [2:0]         dev;
    event_kind_t        kind;
    logic [4:0]         chan;
    logic signed [15:0] value;
  } cond_event_t;

  logic clk = 1'b0;
  logic rst;

  jic_item_if  samples();
  jic_event_if events();
  jic_cfg_if   cfg();

  joystick_input_conditioner DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .events  (events),
    .cfg     (cfg)
  );

  always #5 clk = ~clk;

  // shadow of the block's configuration and level stores
  int         dz_reg;
  int         sat_reg;
  int         gain_reg;
  logic [31:0] btn_level [MAX_DEVICES];
  logic [3:0]  hat_level [MAX_DEVICES][MAX_HATS];

  item_t       sample_feed[$];
  item_t       on_bus;
  cond_event_t due_events[$];
  int          mismatches = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          recv_hold;
  event        hold_events;

  hat_mask_t hat_dirs [8] = '{HAT_UP, HAT_RIGHT_UP, HAT_RIGHT, HAT_RIGHT_DOWN,
                              HAT_DOWN, HAT_LEFT_DOWN, HAT_LEFT, HAT_LEFT_UP};

  function automatic logic signed [15:0] scale_axis(input logic signed [15:0] s);
    int     mag;
    longint p;
    mag = (s < 0) ? -int'(s) : int'(s);
    if (mag > 32767) mag = 32767;
    // dead zone wins over saturation when they overlap
    if (mag <= dz_reg) return 16'sd0;
    if (mag >= sat_reg) begin
      p = 32767;
    end else begin
      p = (longint'(mag - dz_reg) * gain_reg + 2048) >>> 12;
      if (p > 32767) p = 32767;
    end
    return (s < 0) ? 16'(-p) : 16'(p);
  endfunction

  function automatic logic signed [15:0] slider_of(input logic signed [15:0] r);
    longint u;
    u = longint'(r) + 32768;
    return 16'((u * 2 * 32767 + 65535) / 131070);
  endfunction

  function automatic bit condition_sample(input item_t s, output cond_event_t ev);
    logic [3:0] mask;
    ev.dev   = s.device;
    ev.chan  = s.channel;
    ev.kind  = EV_AXIS;
    ev.value = 16'sd0;
    if (s.device >= MAX_DEVICES) return 0;
    case (s.command)
      CMD_AXIS: begin
        if (s.channel >= AXIS_COUNT) return 0;
        ev.value = scale_axis(s.raw_value);
      end
      CMD_SLIDER: begin
        if (s.channel >= SLIDER_COUNT) return 0;
        ev.kind  = EV_SLIDER;
        ev.value = slider_of(s.raw_value);
      end
      CMD_TRIGGER: begin
        if (s.channel >= SLIDER_COUNT) return 0;
        ev.kind  = EV_SLIDER;
        ev.value = (s.raw_value < 0) ? 16'sd0 : s.raw_value;
      end
      CMD_BUTTON: begin
        if (s.channel >= MAX_BUTTONS) return 0;
        if (btn_level[s.device][s.channel] == s.raw_value[0]) return 0;
        btn_level[s.device][s.channel] = s.raw_value[0];
        ev.kind = s.raw_value[0] ? EV_BTN_DOWN : EV_BTN_UP;
      end
      CMD_HAT: begin
        if (s.channel >= MAX_HATS) return 0;
        mask = s.raw_value[3:0];
        if (hat_level[s.device][s.channel] == mask) return 0;
        hat_level[s.device][s.channel] = mask;
        ev.kind = EV_HAT_OFFSET;
        case (mask)
          HAT_UP:         ev.value = 16'sd0;
          HAT_RIGHT_UP:   ev.value = 16'sd1;
          HAT_RIGHT:      ev.value = 16'sd2;
          HAT_RIGHT_DOWN: ev.value = 16'sd3;
          HAT_DOWN:       ev.value = 16'sd4;
          HAT_LEFT_DOWN:  ev.value = 16'sd5;
          HAT_LEFT:       ev.value = 16'sd6;
          HAT_LEFT_UP:    ev.value = 16'sd7;
          default:        ev.kind  = EV_HAT_CENTER;
        endcase
      end
      CMD_CLEAR: begin
        btn_level[s.device] = '0;
        for (int h = 0; h < MAX_HATS; h++) hat_level[s.device][h] = '0;
        return 0;
      end
      default: return 0;
    endcase
    return 1;
  endfunction

  function automatic item_t mk_sample(input logic [2:0] c, input logic [2:0] d,
                                      input logic [4:0] ch, input logic [15:0] r);
    item_t s;
    s.command   = c;
    s.device    = d;
    s.channel   = ch;
    s.raw_value = r;
    return s;
  endfunction

  // axis-like samples cluster around the extremes and both thresholds
  function automatic logic [15:0] axis_raw();
    int v;
    int sgn;
    sgn = ($urandom_range(1) == 1) ? -1 : 1;
    case ($urandom_range(9))
      0:       v = -32768;
      1:       v = sgn * 32767;
      2:       v = sgn * (dz_reg + int'($urandom_range(8)) - 4);
      3:       v = sgn * (sat_reg + int'($urandom_range(8)) - 4);
      4:       v = 0;
      default: v = $urandom;
    endcase
    return 16'(v);
  endfunction

  function automatic item_t rand_sample();
    item_t s;
    int    pick;
    s.device    = 3'($urandom_range(MAX_DEVICES - 1));
    s.raw_value = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      s.command   = CMD_AXIS;
      s.channel   = 5'($urandom_range(AXIS_COUNT - 1));
      s.raw_value = axis_raw();
    end else if (pick < 40) begin
      s.command   = CMD_SLIDER;
      s.channel   = 5'($urandom_range(SLIDER_COUNT - 1));
      s.raw_value = axis_raw();
    end else if (pick < 50) begin
      s.command   = CMD_TRIGGER;
      s.channel   = 5'($urandom_range(SLIDER_COUNT - 1));
      s.raw_value = axis_raw();
    end else if (pick < 70) begin
      s.command = CMD_BUTTON;
      s.channel = 5'($urandom_range(MAX_BUTTONS - 1));
    end else if (pick < 88) begin
      s.command = CMD_HAT;
      s.channel = 5'($urandom_range(MAX_HATS - 1));
      pick = $urandom_range(11);
      if (pick < 8) s.raw_value[3:0] = hat_dirs[pick];
      else if (pick < 10) s.raw_value[3:0] = 4'd0;
    end else if (pick < 95) begin
      s.command = CMD_CLEAR;
      s.channel = 5'($urandom);
    end else begin
      s.command = ($urandom_range(1) == 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      s.channel = 5'($urandom);
    end
    // occasionally any channel, mostly out of range
    if ($urandom_range(9) == 0) s.channel = 5'($urandom);
    return s;
  endfunction

  // driver: offers the next item when the bus is free, with random idle gaps
  always @(posedge clk) begin
    cond_event_t ev;
    if (rst) begin
      samples.valid <= 1'b0;
    end else begin
      if (samples.valid && samples.ready) begin
        if (condition_sample(on_bus, ev)) due_events.push_back(ev);
      end
      if (!samples.valid || samples.ready) begin
        if (sample_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = sample_feed.pop_front();
          samples.valid     <= 1'b1;
          samples.command   <= on_bus.command;
          samples.device    <= on_bus.device;
          samples.channel   <= on_bus.channel;
          samples.raw_value <= on_bus.raw_value;
        end else begin
          samples.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted event against the oldest expectation
  always @(posedge clk) begin
    cond_event_t exp_ev;
    if (rst) begin
      events.ready <= 1'b0;
    end else begin
      if (events.valid && events.ready) begin
        if (due_events.size() == 0) begin
          $error("unexpected event: device %0d kind %0d channel %0d value %0d",
                 events.out_device, events.event_kind, events.out_channel, events.value);
          mismatches++;
        end else begin
          exp_ev = due_events.pop_front();
          if (events.out_device !== exp_ev.dev) begin
            $error("out_device: expected %0d, got %0d", exp_ev.dev, events.out_device);
            mismatches++;
          end
          if (events.event_kind !== exp_ev.kind) begin
            $error("event_kind: expected %0d, got %0d", exp_ev.kind, events.event_kind);
            mismatches++;
          end
          if (events.out_channel !== exp_ev.chan) begin
            $error("out_channel: expected %0d, got %0d", exp_ev.chan, events.out_channel);
            mismatches++;
          end
          if (events.value !== exp_ev.value) begin
            $error("value: expected %0d, got %0d", exp_ev.value, events.value);
            mismatches++;
          end
        end
      end
      events.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long back-pressure stretch on the event side
  initial begin
    recv_hold = 1'b0;
    @(hold_events);
    @(negedge clk);
    recv_hold = 1'b1;
    repeat (LONG_STALL) @(negedge clk);
    recv_hold = 1'b0;
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_feed.size() != 0 || samples.valid || due_events.size() != 0);
    // items without an event may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [15:0] d);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.addr  <= r;
    cfg.data  <= d;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (r)
      REG_DEAD_ZONE:  dz_reg   = int'(d[14:0]);
      REG_SATURATION: sat_reg  = int'(d[14:0]);
      REG_GAIN:       gain_reg = int'(d);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int k);
    int d;
    int s;
    int g;
    case (k)
      0: begin
        d = 0; s = 32767; g = 65535;
      end
      1: begin
        d = 32767; s = 0; g = 0;
      end
      2: begin
        // realistic: gain matches the span between the thresholds
        d = $urandom_range(6000);
        s = $urandom_range(32767, 20000);
        g = (32767 * 4096) / (s - d);
      end
      3: begin
        // top bit set now and then on the 15-bit registers
        d = $urandom_range(65535); s = $urandom_range(65535); g = $urandom_range(65535);
      end
      4: begin
        d = int'(DEAD_ZONE_RST); s = int'(SATURATION_RST); g = int'(GAIN_RST);
      end
      default: begin
        d = $urandom_range(3000);
        s = $urandom_range(32767, d + 1);
        g = $urandom_range(65535);
      end
    endcase
    write_reg(REG_DEAD_ZONE, 16'(d));
    write_reg(REG_SATURATION, 16'(s));
    write_reg(REG_GAIN, 16'(g));
  endtask

  initial begin
    #2_000_000;
    $display("tb_joystick_input_conditioner: FAIL");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    samples.valid     = 1'b0;
    samples.command   = '0;
    samples.device    = '0;
    samples.channel   = '0;
    samples.raw_value = '0;
    events.ready      = 1'b0;
    cfg.valid         = 1'b0;
    cfg.addr          = '0;
    cfg.data          = '0;
    dz_reg            = int'(DEAD_ZONE_RST);
    sat_reg           = int'(SATURATION_RST);
    gain_reg          = int'(GAIN_RST);
    foreach (btn_level[d]) btn_level[d] = '0;
    foreach (hat_level[d, h]) hat_level[d][h] = '0;
    send_idle_pct     = 26;
    recv_idle_pct     = 74;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at reset configuration
    sample_feed.push_back(mk_sample(CMD_AXIS, 3'd0, 5'd0, 16'h7FFF));
    sample_feed.push_back(mk_sample(CMD_AXIS, 3'd1, 5'd5, 16'h8000));
    sample_feed.push_back(mk_sample(CMD_AXIS, 3'd2, 5'd1, 16'd3277));
    sample_feed.push_back(mk_sample(CMD_AXIS, 3'd2, 5'd1, 16'd3278));
    sample_feed.push_back(mk_sample(CMD_AXIS, 3'd3, 5'd2, -16'sd29491));
    sample_feed.push_back(mk_sample(CMD_AXIS, 3'd3, 5'd2, 16'd29490));
    sample_feed.push_back(mk_sample(CMD_AXIS, 3'd0, 5'd6, 16'd100));
    sample_feed.push_back(mk_sample(CMD_SLIDER, 3'd4, 5'd0, 16'h8000));
    sample_feed.push_back(mk_sample(CMD_SLIDER, 3'd4, 5'd1, 16'h7FFF));
    sample_feed.push_back(mk_sample(CMD_SLIDER, 3'd5, 5'd0, 16'd0));
    sample_feed.push_back(mk_sample(CMD_SLIDER, 3'd5, 5'd2, 16'd5));
    sample_feed.push_back(mk_sample(CMD_TRIGGER, 3'd6, 5'd0, 16'hFFFF));
    sample_feed.push_back(mk_sample(CMD_TRIGGER, 3'd6, 5'd1, 16'h7FFF));
    sample_feed.push_back(mk_sample(CMD_TRIGGER, 3'd6, 5'd2, 16'd7));
    sample_feed.push_back(mk_sample(CMD_BUTTON, 3'd7, 5'd31, 16'd1));
    sample_feed.push_back(mk_sample(CMD_BUTTON, 3'd7, 5'd31, 16'd3));
    sample_feed.push_back(mk_sample(CMD_BUTTON, 3'd7, 5'd0, 16'hFFFE));
    sample_feed.push_back(mk_sample(CMD_HAT, 3'd7, 5'd3, 16'(HAT_RIGHT_UP)));
    sample_feed.push_back(mk_sample(CMD_HAT, 3'd7, 5'd3, 16'(HAT_UP | HAT_DOWN)));
    sample_feed.push_back(mk_sample(CMD_HAT, 3'd7, 5'd3, 16'd0));
    sample_feed.push_back(mk_sample(CMD_HAT, 3'd7, 5'd3, {12'hFFF, 4'(HAT_LEFT_UP)}));
    sample_feed.push_back(mk_sample(CMD_HAT, 3'd7, 5'd4, 16'(HAT_UP)));
    sample_feed.push_back(mk_sample(CMD_CLEAR, 3'd7, 5'd0, 16'd0));
    sample_feed.push_back(mk_sample(CMD_BUTTON, 3'd7, 5'd31, 16'd0));
    sample_feed.push_back(mk_sample(CMD_HAT, 3'd7, 5'd3,
                                    16'(HAT_UP | HAT_RIGHT | HAT_DOWN | HAT_LEFT)));
    sample_feed.push_back(mk_sample(CMD_SPARE_LO, 3'd1, 5'd0, 16'h7FFF));
    sample_feed.push_back(mk_sample(CMD_SPARE_HI, 3'd2, 5'd1, 16'd1));
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 26; recv_idle_pct = 74; end
        1: begin send_idle_pct = 74; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int sub = 0; sub < 2; sub++) begin
        apply_settings(2 * ph + sub);
        @(negedge clk);
        // hold the event side while the sender keeps pushing items
        if (ph == 2 && sub == 0) -> hold_events;
        repeat (RANDOM_CHUNK) sample_feed.push_back(rand_sample());
        wait_drained();
      end
    end

    if (mismatches == 0) $display("tb_joystick_input_conditioner: PASS");
    else $display("tb_joystick_input_conditioner: FAIL");
    $finish;
  end

endmodule
